// ===== hdl/b58d_pkg.sv =====
package b58d_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int BUF_BYTES_DEF = 48;
    localparam int MAX_RESULTS   = 64;

    localparam int RADIX   = 58;
    localparam int DIGIT_W = 6;
    localparam int PROD_W  = 14;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIN,
        S_RD,
        S_LD
    } b58d_state_t;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] digit;
    } b58d_digit_t;

    // Map an ASCII character onto its base58 digit.
    function automatic b58d_digit_t digit_of(input logic [7:0] ch);
        b58d_digit_t r;
        r.ok    = 1'b1;
        r.digit = '0;
        case (ch) inside
            [8'h31:8'h39]: r.digit = DIGIT_W'(ch - 8'h31);
            [8'h41:8'h48]: r.digit = DIGIT_W'(ch - 8'h41 + 8'd9);
            [8'h4A:8'h4E]: r.digit = DIGIT_W'(ch - 8'h4A + 8'd17);
            [8'h50:8'h5A]: r.digit = DIGIT_W'(ch - 8'h50 + 8'd22);
            [8'h61:8'h6B]: r.digit = DIGIT_W'(ch - 8'h61 + 8'd33);
            [8'h6D:8'h7A]: r.digit = DIGIT_W'(ch - 8'h6D + 8'd44);
            default:       r.ok    = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/b58d_buf_mem.sv =====
module b58d_buf_mem #(
    parameter int DEPTH = 48
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [7:0]                 wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read word until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/b58d_mac.sv =====
module b58d_mac (
    input  logic [7:0]                 data,
    input  logic [b58d_pkg::DIGIT_W-1:0] carry_in,
    output logic [7:0]                 byte_out,
    output logic [b58d_pkg::DIGIT_W-1:0] carry_out
);

    import b58d_pkg::*;

    logic [PROD_W-1:0] acc;

    // One column of buffer * 58 + carry; carry out never exceeds 57.
    assign acc       = PROD_W'(data) * PROD_W'(RADIX) + PROD_W'(carry_in);
    assign byte_out  = acc[7:0];
    assign carry_out = acc[PROD_W-1:8];

endmodule

// ===== hdl/base58_decoder_unit.sv =====
// Streaming base58 decoder. Feed one ASCII character per request, in_last on the final
// one; the decoded big-endian bytes come out one per request, leading '1' characters
// giving zero bytes, out_last on the final byte. A bad character or a string longer
// than MAX_CHARS yields one result with out_byte 0 and the error in out_status. A valid
// character holds the input for the multiply-by-58 carry pass, which reads and writes
// back one byte of the buffer memory per cycle; a character that is rejected, or that
// arrives after an error, is taken without a pass. After the last character the block
// passes through a setup state, which also loads the lone error result of a failed string,
// and then for each decoded byte reads the buffer (leading zero bytes skip the read) and
// loads the output register, waiting while the output is stalled; at most 64 results are
// given per string. No clearing pass is needed after reset or between strings: the buffer
// is treated as zero until the first pass of a string rewrites it.
// A result waiting in the output register does not block new characters.
module base58_decoder_unit #(
    parameter int MAX_CHARS = b58d_pkg::MAX_CHARS_DEF,
    parameter int BUF_BYTES = b58d_pkg::BUF_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_status,
    output logic       out_last
);

    import b58d_pkg::*;

    localparam int ADDR_W  = $clog2(BUF_BYTES);
    localparam int FIRST_W = $clog2(BUF_BYTES + 1);
    localparam int CNT_W   = $clog2(MAX_CHARS + 1);
    localparam int TOT_W   = $clog2(MAX_CHARS + BUF_BYTES + MAX_RESULTS + 1);

    b58d_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   leading_reg, leading_next;
    logic               still_reg, still_next;
    logic [1:0]         err_reg, err_next;
    logic               fresh_reg, fresh_next;
    logic               last_pend_reg, last_pend_next;
    logic [DIGIT_W-1:0] carry_reg, carry_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [FIRST_W-1:0] first_reg, first_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [TOT_W-1:0]   k_reg, k_next;
    logic [TOT_W-1:0]   total_reg, total_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [7:0]         mem_wdata, mem_rdata;

    logic [7:0]         mac_data;
    logic [7:0]         mac_byte;
    logic [DIGIT_W-1:0] mac_carry;

    b58d_digit_t        dig;
    logic               accept;
    logic               too_long;
    logic               pass_start;
    logic               out_free;
    logic [FIRST_W-1:0] byte_cnt;
    logic [TOT_W-1:0]   sum_cnt;
    logic [TOT_W-1:0]   total_calc;
    logic               zero_phase;
    logic               final_k;

    b58d_buf_mem #(
        .DEPTH (BUF_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    b58d_mac u_mac (
        .data      (mac_data),
        .carry_in  (carry_reg),
        .byte_out  (mac_byte),
        .carry_out (mac_carry)
    );

    // Shared decode of the current request and emission bookkeeping.
    assign dig        = digit_of(in_char);
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign too_long   = (cnt_reg >= CNT_W'(MAX_CHARS));
    assign pass_start = accept && (err_reg == STATUS_OK) && !too_long && dig.ok;
    assign out_free   = !out_valid_reg || out_ready;

    // Until the first pass of a string, the memory holds stale bytes: read them as zero.
    assign mac_data   = fresh_reg ? 8'd0 : mem_rdata;

    assign byte_cnt   = FIRST_W'(BUF_BYTES) - first_reg;
    assign sum_cnt    = TOT_W'(leading_reg) + TOT_W'(byte_cnt);
    assign total_calc = (sum_cnt > TOT_W'(MAX_RESULTS)) ? TOT_W'(MAX_RESULTS) : sum_cnt;
    assign zero_phase = (k_reg < TOT_W'(leading_reg));
    assign final_k    = (k_reg == total_reg - TOT_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pass_start)
                begin
                    state_next = S_MUL;
                end
                else if (accept && in_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                if (idx_reg == '0)
                begin
                    state_next = last_pend_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (err_reg != STATUS_OK)
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (total_calc == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                if (out_free)
                begin
                    state_next = final_k ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory control and output register.
    always_comb
    begin
        cnt_next        = cnt_reg;
        leading_next    = leading_reg;
        still_next      = still_reg;
        err_next        = err_reg;
        fresh_next      = fresh_reg;
        last_pend_next  = last_pend_reg;
        carry_next      = carry_reg;
        idx_next        = idx_reg;
        first_next      = first_reg;
        rd_ptr_next     = rd_ptr_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = mac_byte;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        // Drop the held result once the sink takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (err_reg == STATUS_OK))
                begin
                    if (too_long)
                    begin
                        err_next = STATUS_TOO_LONG;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (!dig.ok)
                        begin
                            err_next = STATUS_BAD_CHAR;
                        end
                        else
                        begin
                            if (still_reg && (in_char == 8'h31))
                            begin
                                leading_next = leading_reg + CNT_W'(1);
                            end
                            else
                            begin
                                still_next = 1'b0;
                            end
                            // Start the carry pass at the least significant byte.
                            mem_re         = 1'b1;
                            mem_raddr      = ADDR_W'(BUF_BYTES - 1);
                            idx_next       = ADDR_W'(BUF_BYTES - 1);
                            carry_next     = dig.digit;
                            first_next     = FIRST_W'(BUF_BYTES);
                            last_pend_next = in_last;
                        end
                    end
                end
            end
            S_MUL:
            begin
                // Write back this byte while the next one is read: addresses never meet.
                mem_we     = 1'b1;
                carry_next = mac_carry;
                if (mac_byte != 8'd0)
                begin
                    first_next = FIRST_W'(idx_reg);
                end
                if (idx_reg == '0)
                begin
                    fresh_next = 1'b0;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - ADDR_W'(1);
                    idx_next  = idx_reg - ADDR_W'(1);
                end
            end
            S_FIN:
            begin
                total_next  = total_calc;
                k_next      = '0;
                rd_ptr_next = ADDR_W'(first_reg);
                if (err_reg != STATUS_OK)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = 8'd0;
                        out_status_next = err_reg;
                        out_last_next   = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                if (!zero_phase)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_ptr_reg;
                end
            end
            S_LD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = zero_phase ? 8'd0 : mem_rdata;
                    out_status_next = STATUS_OK;
                    out_last_next   = final_k;
                    k_next          = k_reg + TOT_W'(1);
                    if (!zero_phase)
                    begin
                        rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        // Clear the string state once its results are out.
        if ((state_reg != S_IDLE) && (state_next == S_IDLE) && (state_reg != S_MUL))
        begin
            cnt_next       = '0;
            leading_next   = '0;
            still_next     = 1'b1;
            err_next       = STATUS_OK;
            fresh_next     = 1'b1;
            last_pend_next = 1'b0;
            first_next     = FIRST_W'(BUF_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            leading_reg   <= '0;
            still_reg     <= 1'b1;
            err_reg       <= STATUS_OK;
            fresh_reg     <= 1'b1;
            last_pend_reg <= 1'b0;
            first_reg     <= FIRST_W'(BUF_BYTES);
            k_reg         <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            leading_reg   <= leading_next;
            still_reg     <= still_next;
            err_reg       <= err_next;
            fresh_reg     <= fresh_next;
            last_pend_reg <= last_pend_next;
            first_reg     <= first_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg      <= carry_next;
        idx_reg        <= idx_next;
        rd_ptr_reg     <= rd_ptr_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // The carry pass never reads the entry it writes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("buffer read and write hit the same entry");

    // An error result is a lone zero byte that closes the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status != STATUS_OK)) |-> (out_last && (out_byte == 8'd0)))
        else $error("error result is not a single last zero byte");

    // Emission stays inside the result count fixed in the setup state after the last character.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RD) || (state_reg == S_LD)) |-> (k_reg < total_reg))
        else $error("result index ran past the result count");

    // The first nonzero position never points beyond the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        first_reg <= FIRST_W'(BUF_BYTES))
        else $error("first nonzero position out of range");

endmodule
